// ----- src/hiscr_pkg.sv -----
// ----------------------------------------------------------------------------
// hiscr_pkg: shared types and constants
// Widths, job record, state encodings and register indexes of the
// homography inlier scorer.
// ----------------------------------------------------------------------------
package hiscr_pkg;

	localparam int HW = 43;          // homogeneous coordinate, signed
	localparam int QW = HW + 16;     // quotient width of the Q16 divide
	localparam int PW = 20;          // point coordinate width
	localparam int CW = 21;          // coefficient width

	localparam logic [18:0] CHI_T    = 19'd392626;
	localparam logic [19:0] CHI_2T   = 20'd785252;
	localparam logic [39:0] ERR_CAP  = 40'h80_0000_0000;
	localparam logic [30:0] DIST_CAP = 31'h7FFF_FFFF;

	localparam logic [7:0] REG_FWD0 = 8'd0;
	localparam logic [7:0] REG_FWD1 = 8'd1;
	localparam logic [7:0] REG_FWD2 = 8'd2;
	localparam logic [7:0] REG_INV0 = 8'd3;
	localparam logic [7:0] REG_INV1 = 8'd4;
	localparam logic [7:0] REG_INV2 = 8'd5;
	localparam logic [7:0] REG_FOCAL = 8'd6;
	localparam logic [7:0] REG_ISQ  = 8'd7;

	typedef struct packed {
		logic [5:0][HW-1:0] h;     // fwd h0..h2, inv h0..h2
		logic [PW-1:0]      ax;
		logic [PW-1:0]      ay;
		logic [PW-1:0]      bx;
		logic [PW-1:0]      by;
		logic               set_end;
		logic               zero;  // a divisor is zero
	} hiscr_job_t;

	typedef enum logic [1:0] {F_IDLE, F_CALC, F_PUSH} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE, B_DIV_START, B_DIV_WAIT, B_ERR, B_MUL, B_SQ,
		B_CHI_MUL, B_CHI_CMP, B_SCORE
	} back_state_t;

endpackage

// ----- src/hiscr_ifs.sv -----
// ----------------------------------------------------------------------------
// hiscr_ifs: channel interfaces
// Match input, result output and register write channels.
// ----------------------------------------------------------------------------
interface hiscr_in_if;
	logic               valid;
	logic               ready;
	logic signed [19:0] src_x;
	logic signed [19:0] src_y;
	logic signed [19:0] dst_x;
	logic signed [19:0] dst_y;
	logic               set_end;
	modport source (output valid, src_x, src_y, dst_x, dst_y, set_end, input ready);
	modport sink (input valid, src_x, src_y, dst_x, dst_y, set_end, output ready);
endinterface

interface hiscr_out_if;
	logic        valid;
	logic        ready;
	logic        is_inlier;
	logic [19:0] pair_score;
	logic [31:0] score_total;
	logic [12:0] inliers_total;
	logic        set_done;
	modport source (output valid, is_inlier, pair_score, score_total, inliers_total,
		set_done, input ready);
	modport sink (input valid, is_inlier, pair_score, score_total, inliers_total,
		set_done, output ready);
endinterface

interface hiscr_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/homography_inlier_scorer.sv -----
// ----------------------------------------------------------------------------
// homography_inlier_scorer: symmetric transfer error inlier scoring
// Scores point matches against a homography and its inverse.
// ----------------------------------------------------------------------------
// One result item per match item. The intake forms the six homogeneous
// coordinates of a match (one homography row a cycle) and hands the match
// through a two-entry queue to the scoring engine. The engine runs the four
// perspective divides one after another in a single restoring divider that
// retires one quotient bit a cycle (59 bits), then forms the clamped pixel
// errors, the two chi-square values and the score. That divider loop sets
// the rate: the engine takes a new match only once it is through with the
// last one, while intake of the next match overlaps. A zero divisor skips
// the divides and yields an outlier. The result register lets the engine
// finish a match while the previous result waits. Score and inlier totals
// saturate and clear after the item whose set_end is high. Write registers
// only while idle; cfg is always ready and indexes beyond the register list
// are dropped.
// ----------------------------------------------------------------------------
module homography_inlier_scorer import hiscr_pkg::*; #(
	parameter int MAX_MATCHES = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	hiscr_in_if.sink     pairs,
	hiscr_out_if.source  results,
	hiscr_cfg_if.sink    cfg
);
	localparam logic [12:0] InlCap = 13'((MAX_MATCHES < 8191) ? MAX_MATCHES : 8191);

	logic [2:0][62:0] fwd_q, inv_q;
	logic [39:0]      focal_q;
	logic [31:0]      isq_q;

	assign cfg.ready = 1'b1;

	// register file; reset to identity homographies, unit focal and sigma
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q[0] <= 63'd65536;
			fwd_q[1] <= 63'd65536 << 21;
			fwd_q[2] <= 63'd65536 << 42;
			inv_q[0] <= 63'd65536;
			inv_q[1] <= 63'd65536 << 21;
			inv_q[2] <= 63'd65536 << 42;
			focal_q  <= 40'd268435712;
			isq_q    <= 32'd16777216;
		end else if (cfg.valid) begin
			priority case (cfg.index)
				REG_FWD0:  fwd_q[0] <= cfg.data[62:0];
				REG_FWD1:  fwd_q[1] <= cfg.data[62:0];
				REG_FWD2:  fwd_q[2] <= cfg.data[62:0];
				REG_INV0:  inv_q[0] <= cfg.data[62:0];
				REG_INV1:  inv_q[1] <= cfg.data[62:0];
				REG_INV2:  inv_q[2] <= cfg.data[62:0];
				REG_FOCAL: focal_q  <= cfg.data[39:0];
				REG_ISQ:   isq_q    <= cfg.data[31:0];
				default: ;
			endcase
		end
	end

	hiscr_job_t f_job, b_job;
	logic       f_valid, f_ready, b_valid, b_ready;

	// intake: accept a match, form homogeneous coordinates
	hiscr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pairs    (pairs),
		.fwd_rows (fwd_q),
		.inv_rows (inv_q),
		.job      (f_job),
		.job_valid(f_valid),
		.job_ready(f_ready)
	);

	// hold up to two matches between intake and engine
	hiscr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_job  (f_job),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.pop_job   (b_job),
		.pop_valid (b_valid),
		.pop_ready (b_ready)
	);

	// engine: divide, error, chi-square, score, totals
	hiscr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (b_job),
		.job_valid(b_valid),
		.job_ready(b_ready),
		.focal    (focal_q),
		.isq      (isq_q),
		.inl_cap  (InlCap),
		.results  (results)
	);
endmodule

// ----- src/hiscr_div.sv -----
// ----------------------------------------------------------------------------
// hiscr_div: restoring divider
// Computes (num << 16) / den on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hiscr_div import hiscr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [HW-1:0] num,
	input  logic [HW-1:0] den,
	output logic          busy,
	output logic [QW-1:0] quo
);
	localparam int CNTW = $clog2(QW);

	logic [QW-1:0]   quo_q;
	logic [HW-1:0]   rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic [HW+1:0]   trial;

	assign trial = {1'b0, rem_q, quo_q[QW-1]} - {2'b00, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNTW'(QW - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= {num, 16'b0};
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[HW+1]) begin
				rem_q <= trial[HW-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[HW-2:0], quo_q[QW-1]};
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
endmodule

// ----- src/hiscr_front.sv -----
// ----------------------------------------------------------------------------
// hiscr_front: match intake
// Accepts a match and forms its six homogeneous coordinates, one row a cycle.
// ----------------------------------------------------------------------------
module hiscr_front import hiscr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	hiscr_in_if.sink            pairs,
	input  logic [2:0][62:0]    fwd_rows,
	input  logic [2:0][62:0]    inv_rows,
	output hiscr_job_t          job,
	output logic                job_valid,
	input  logic                job_ready
);
	front_state_t st_q, st_d;
	logic [2:0]   row_q;
	logic [PW-1:0] ax_q, ay_q, bx_q, by_q;
	logic          end_q;
	logic [5:0][HW-1:0] h_q;

	logic [1:0]           ridx;
	logic [62:0]          row;
	logic signed [CW-1:0] c0, c1, c2;
	logic signed [PW-1:0] x, y;
	logic signed [HW-1:0] h_calc;

	always_comb begin
		ridx = (row_q < 3'd3) ? row_q[1:0] : 2'(row_q - 3'd3);
		row  = (row_q < 3'd3) ? fwd_rows[ridx] : inv_rows[ridx];
		x    = (row_q < 3'd3) ? $signed(ax_q) : $signed(bx_q);
		y    = (row_q < 3'd3) ? $signed(ay_q) : $signed(by_q);
		c0   = $signed(row[20:0]);
		c1   = $signed(row[41:21]);
		c2   = $signed(row[62:42]);
		h_calc = c0 * x + c1 * y + (HW'(c2) <<< 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= F_IDLE;
		else         st_q <= st_d;
	end

	always_comb begin
		st_d            = st_q;
		pairs.ready     = 1'b0;
		job_valid       = 1'b0;
		unique case (st_q)
			F_IDLE: begin
				pairs.ready = 1'b1;
				if (pairs.valid) st_d = F_CALC;
			end
			F_CALC: begin
				if (row_q == 3'd5) st_d = F_PUSH;
			end
			F_PUSH: begin
				job_valid = 1'b1;
				if (job_ready) st_d = F_IDLE;
			end
			default: st_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == F_IDLE && pairs.valid) begin
			ax_q  <= pairs.src_x;
			ay_q  <= pairs.src_y;
			bx_q  <= pairs.dst_x;
			by_q  <= pairs.dst_y;
			end_q <= pairs.set_end;
			row_q <= '0;
		end else if (st_q == F_CALC) begin
			h_q[row_q] <= h_calc;
			row_q      <= row_q + 3'd1;
		end
	end

	always_comb begin
		job.h       = h_q;
		job.ax      = ax_q;
		job.ay      = ay_q;
		job.bx      = bx_q;
		job.by      = by_q;
		job.set_end = end_q;
		job.zero    = (h_q[2] == '0) || (h_q[5] == '0);
	end
endmodule

// ----- src/hiscr_queue.sv -----
// ----------------------------------------------------------------------------
// hiscr_queue: two-entry job queue
// Decouples the intake from the scoring engine.
// ----------------------------------------------------------------------------
module hiscr_queue import hiscr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  hiscr_job_t push_job,
	input  logic       push_valid,
	output logic       push_ready,
	output hiscr_job_t pop_job,
	output logic       pop_valid,
	input  logic       pop_ready
);
	hiscr_job_t mem [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_job;
	end
endmodule

// ----- src/hiscr_back.sv -----
// ----------------------------------------------------------------------------
// hiscr_back: scoring engine
// Divides, forms transfer errors and chi-square values, scores and totals.
// ----------------------------------------------------------------------------
module hiscr_back import hiscr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  hiscr_job_t  job,
	input  logic        job_valid,
	output logic        job_ready,
	input  logic [39:0] focal,
	input  logic [31:0] isq,
	input  logic [12:0] inl_cap,
	hiscr_out_if.source results
);
	back_state_t st_q, st_d;
	hiscr_job_t  job_q;
	logic [1:0]  k_q;
	logic        j_q;
	logic        neg_q;
	logic [39:0] m_q;
	logic [30:0] d_q;
	logic [62:0] dsum1_q, dsum2_q;
	logic [53:0] plo_q;
	logic [52:0] phi_q;
	logic [1:0]  lt_q;
	logic [1:0][18:0] chi_q;
	logic [31:0] score_q;
	logic [12:0] inl_q;
	logic        ovalid_q;

	logic          div_start, div_busy;
	logic [QW-1:0] quo;
	logic [HW-1:0] num_s, den_s;
	logic [HW-1:0] num_m, den_m;
	logic          load;

	// numerator and divisor of the current divide
	always_comb begin
		num_s = job_q.h[k_q[1] ? (3'd3 + 3'(k_q[0])) : 3'(k_q[0])];
		den_s = job_q.h[k_q[1] ? 3'd5 : 3'd2];
		num_m = num_s[HW-1] ? (~num_s + 1'b1) : num_s;
		den_m = den_s[HW-1] ? (~den_s + 1'b1) : den_s;
	end

	hiscr_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_m),
		.den   (den_m),
		.busy  (div_busy),
		.quo   (quo)
	);

	// transfer error against the measured point
	logic signed [PW-1:0] meas;
	logic signed [60:0]   p_s, e_s;
	logic [60:0]          e_m;
	logic [19:0]          f_sel;
	logic [59:0]          prod;
	logic [61:0]          sq;
	logic [62:0]          dsel;
	logic [42:0]          dd;
	logic [75:0]          chi_full;
	logic [51:0]          chi;

	always_comb begin
		unique case (k_q)
			2'd0: meas = $signed(job_q.bx);
			2'd1: meas = $signed(job_q.by);
			2'd2: meas = $signed(job_q.ax);
			2'd3: meas = $signed(job_q.ay);
			default: meas = '0;
		endcase
		p_s   = neg_q ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
		e_s   = p_s - 61'(meas);
		e_m   = e_s[60] ? 61'(-e_s) : 61'(e_s);
		f_sel = k_q[0] ? focal[39:20] : focal[19:0];
		prod  = m_q * f_sel;
		sq    = d_q * d_q;
		dsel  = j_q ? dsum2_q : dsum1_q;
		dd    = (dsel[62:59] != 4'd0) ? '1 : dsel[58:16];
		chi_full = {1'b0, phi_q, 22'b0} + 76'(plo_q);
		chi   = chi_full[75:24];
	end

	// scoring of a finished match
	logic        inl;
	logic [19:0] ps;
	logic [32:0] ssum;

	always_comb begin
		inl  = !job_q.zero && lt_q[0] && lt_q[1];
		ps   = inl ? (CHI_2T - 20'(chi_q[0]) - 20'(chi_q[1])) : 20'd0;
		ssum = {1'b0, score_q} + 33'(ps);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= B_IDLE;
		else         st_q <= st_d;
	end

	always_comb begin
		st_d      = st_q;
		job_ready = 1'b0;
		div_start = 1'b0;
		load      = 1'b0;
		unique case (st_q)
			B_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) st_d = job.zero ? B_SCORE : B_DIV_START;
			end
			B_DIV_START: begin
				div_start = 1'b1;
				st_d      = B_DIV_WAIT;
			end
			B_DIV_WAIT: if (!div_busy) st_d = B_ERR;
			B_ERR:      st_d = B_MUL;
			B_MUL:      st_d = B_SQ;
			B_SQ:       st_d = (k_q == 2'd3) ? B_CHI_MUL : B_DIV_START;
			B_CHI_MUL:  st_d = B_CHI_CMP;
			B_CHI_CMP:  st_d = j_q ? B_SCORE : B_CHI_MUL;
			B_SCORE: begin
				if (!ovalid_q || results.ready) begin
					load = 1'b1;
					st_d = B_IDLE;
				end
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			B_IDLE: begin
				job_q   <= job;
				k_q     <= '0;
				j_q     <= 1'b0;
				dsum1_q <= '0;
				dsum2_q <= '0;
			end
			B_DIV_START: neg_q <= num_s[HW-1] ^ den_s[HW-1];
			B_ERR: m_q <= (e_m >= 61'(ERR_CAP)) ? ERR_CAP : e_m[39:0];
			B_MUL: d_q <= (prod[59:8] > 52'(DIST_CAP)) ? DIST_CAP : prod[38:8];
			B_SQ: begin
				if (k_q[1]) dsum2_q <= dsum2_q + 63'(sq);
				else        dsum1_q <= dsum1_q + 63'(sq);
				k_q <= k_q + 2'd1;
			end
			B_CHI_MUL: begin
				plo_q <= dd[21:0] * isq;
				phi_q <= dd[42:22] * isq;
			end
			B_CHI_CMP: begin
				chi_q[j_q] <= chi[18:0];
				lt_q[j_q]  <= (chi < 52'(CHI_T));
				j_q        <= 1'b1;
			end
			default: ;
		endcase
		if (load) begin
			results.is_inlier     <= inl;
			results.pair_score    <= ps;
			results.score_total   <= ssum[32] ? 32'hFFFF_FFFF : ssum[31:0];
			results.inliers_total <= (inl && inl_q < inl_cap) ? inl_q + 13'd1 : inl_q;
			results.set_done      <= job_q.set_end;
		end
	end

	// running totals and the result register's valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q  <= '0;
			inl_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
				if (job_q.set_end) begin
					score_q <= '0;
					inl_q   <= '0;
				end else if (inl) begin
					score_q <= ssum[32] ? 32'hFFFF_FFFF : ssum[31:0];
					if (inl_q < inl_cap) inl_q <= inl_q + 13'd1;
				end
			end else if (results.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign results.valid = ovalid_q;
endmodule

// ----- src/hiscr_checker.sv -----
// ----------------------------------------------------------------------------
// hiscr_checker: result port checks
// Watches the result channel of the scorer.
// ----------------------------------------------------------------------------
module hiscr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        is_inlier,
	input logic [19:0] pair_score,
	input logic [12:0] inliers_total
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(pair_score)
			&& $stable(inliers_total))
		else $error("result changed while stalled");

	a_outlier_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !is_inlier |-> pair_score == 20'd0)
		else $error("outlier with nonzero score");

	a_inlier_score: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_inlier |-> pair_score != 20'd0 && pair_score <= 20'd785252)
		else $error("inlier score out of range");

	a_inlier_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_inlier |-> inliers_total != 13'd0)
		else $error("inlier with zero count");
endmodule

bind homography_inlier_scorer hiscr_checker u_hiscr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (results.valid),
	.res_ready    (results.ready),
	.is_inlier    (results.is_inlier),
	.pair_score   (results.pair_score),
	.inliers_total(results.inliers_total)
);

// ----- tb/tb_homography_inlier_scorer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_homography_inlier_scorer: self-checking bench for the inlier scorer
// Streams point matches under several homography and noise settings,
// predicts every result item from an internal fixed-point model of the
// symmetric transfer error, and checks each result field by field.
// ----------------------------------------------------------------------------
module tb_homography_inlier_scorer;
	import hiscr_pkg::*;

	localparam int  CLK_HALF   = 6;
	localparam int  MAX_M      = 4096;
	localparam int  STALL_LIM  = 40000;  // cycles with no accepted item
	localparam int  DRAIN_WAIT = 400;    // longer than one item takes end to end
	localparam logic [7:0] REG_BAD_LO = 8'd8;
	localparam logic [7:0] REG_BAD_HI = 8'd255;

	typedef struct {
		logic signed [19:0] ax, ay, bx, by;
		logic               last;
	} match_t;

	typedef struct {
		logic        inl;
		logic [19:0] pscore;
		logic [31:0] stotal;
		logic [12:0] itotal;
		logic        done;
	} score_t;

	// ------------------------------------------------------------------------
	// Scoreboard: holds its own copy of the registers and totals, predicts
	// the result of each accepted match and checks results in order.
	// ------------------------------------------------------------------------
	class score_board;
		logic [62:0] fwd[3], inv[3];
		logic [39:0] focal;
		logic [31:0] isq;
		longint unsigned score_acc, inl_acc;
		score_t      pending[$];
		int          errors;

		function new();
			for (int r = 0; r < 3; r++) begin
				fwd[r] = 63'(64'd65536 << (21 * r));
				inv[r] = fwd[r];
			end
			focal = 40'd268435712;
			isq = 32'd16777216;
			score_acc = 0;
			inl_acc = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [7:0] idx, logic [63:0] val);
			case (idx)
				REG_FWD0, REG_FWD1, REG_FWD2: fwd[idx - REG_FWD0] = val[62:0];
				REG_INV0, REG_INV1, REG_INV2: inv[idx - REG_INV0] = val[62:0];
				REG_FOCAL: focal = val[39:0];
				REG_ISQ:   isq = val[31:0];
				default: ;  // drop writes beyond the list
			endcase
		endfunction

		function longint unsigned magn(longint v);
			return v < 0 ? 64'(-v) : 64'(v);
		endfunction

		// perspective map of one point, 0 on a zero third coordinate
		function bit map_point(logic [62:0] rows[3], longint x, longint y,
				output longint px, output longint py);
			longint h[3];
			longint unsigned q;
			for (int r = 0; r < 3; r++)
				h[r] = longint'($signed(rows[r][20:0])) * x
					+ longint'($signed(rows[r][41:21])) * y
					+ longint'($signed(rows[r][62:42])) * 65536;
			px = 0;
			py = 0;
			if (h[2] == 0)
				return 0;
			q = (magn(h[0]) << 16) / magn(h[2]);
			px = ((h[0] < 0) != (h[2] < 0)) ? -longint'(q) : longint'(q);
			q = (magn(h[1]) << 16) / magn(h[2]);
			py = ((h[1] < 0) != (h[2] < 0)) ? -longint'(q) : longint'(q);
			return 1;
		endfunction

		function longint unsigned pix_err_sq(longint p, longint m, longint unsigned f);
			longint unsigned e, d;
			e = magn(p - m);
			if (e > (64'd1 << 40))
				e = 64'd1 << 40;
			d = (e * f) >> 8;
			if (d > 64'h7FFF_FFFF)
				d = 64'h7FFF_FFFF;
			return d * d;
		endfunction

		function longint unsigned chi(longint unsigned dsum);
			longint unsigned d, a, b;
			d = dsum >> 16;
			a = d * longint'(isq[31:16]);
			b = d * longint'(isq[15:0]);
			return (a >> 8) + ((((a & 64'hFF) << 16) + b) >> 24);
		endfunction

		function void note_match(match_t m);
			longint hx, hy, gx, gy;
			longint unsigned fx, fy, c1, c2, ps;
			score_t s;
			fx = 64'(focal[19:0]);
			fy = 64'(focal[39:20]);
			ps = 0;
			s.inl = 1'b0;
			if (map_point(fwd, longint'(m.ax), longint'(m.ay), hx, hy)
					&& map_point(inv, longint'(m.bx), longint'(m.by), gx, gy)) begin
				c1 = chi(pix_err_sq(hx, longint'(m.bx), fx)
					+ pix_err_sq(hy, longint'(m.by), fy));
				c2 = chi(pix_err_sq(gx, longint'(m.ax), fx)
					+ pix_err_sq(gy, longint'(m.ay), fy));
				if (c1 < CHI_T && c2 < CHI_T) begin
					s.inl = 1'b1;
					ps = 2 * CHI_T - c1 - c2;
					score_acc += ps;
					if (score_acc > 64'hFFFF_FFFF)
						score_acc = 64'hFFFF_FFFF;
					if (inl_acc < MAX_M)
						inl_acc++;
				end
			end
			s.pscore = ps[19:0];
			s.stotal = score_acc[31:0];
			s.itotal = inl_acc[12:0];
			s.done = m.last;
			if (m.last) begin
				score_acc = 0;
				inl_acc = 0;
			end
			pending = {pending, s};
		endfunction

		function void check_result(score_t r);
			score_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result item inl=%0b score=%0h", $time,
					r.inl, r.pscore);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (r.inl !== e.inl) begin
				$display("%0t: is_inlier exp %0h act %0h", $time, e.inl, r.inl);
				errors++;
			end
			if (r.pscore !== e.pscore) begin
				$display("%0t: pair_score exp %0h act %0h", $time, e.pscore, r.pscore);
				errors++;
			end
			if (r.stotal !== e.stotal) begin
				$display("%0t: score_total exp %0h act %0h", $time, e.stotal, r.stotal);
				errors++;
			end
			if (r.itotal !== e.itotal) begin
				$display("%0t: inliers_total exp %0h act %0h", $time, e.itotal, r.itotal);
				errors++;
			end
			if (r.done !== e.done) begin
				$display("%0t: set_done exp %0h act %0h", $time, e.done, r.done);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	hiscr_in_if  pairs();
	hiscr_out_if results();
	hiscr_cfg_if cfg();

	homography_inlier_scorer #(.MAX_MATCHES(MAX_M)) u_top (
		.clk(clk), .arst_n(arst_n), .pairs(pairs), .results(results), .cfg(cfg)
	);

	score_board sb = new();
	bit send_gaps = 1;      // sender idles between items
	bit recv_gaps = 1;      // receiver stalls between items
	bit hold_request = 0;   // ask the receiver for one long hold-off
	int idle_cycles = 0;

	initial begin
		clk = 0;
		forever #CLK_HALF clk = ~clk;
	end

	// Watchdog: any accepted item on any channel restarts the count.
	always @(posedge clk) begin
		if ((pairs.valid && pairs.ready) || (results.valid && results.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIM) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Result monitor: sample at the edge, values are the pre-edge ones.
	always @(posedge clk) begin
		score_t r;
		if (arst_n && results.valid && results.ready) begin
			r.inl = results.is_inlier;
			r.pscore = results.pair_score;
			r.stotal = results.score_total;
			r.itotal = results.inliers_total;
			r.done = results.set_done;
			sb.check_result(r);
		end
	end

	// Receiver: stall a random number of cycles before each item; a hold
	// request turns one stall into a long one so the block backs up.
	initial begin
		int n;
		results.ready = 0;
		wait (arst_n);
		forever begin
			n = recv_gaps ? $urandom_range(0, 15) : 0;
			if (hold_request) begin
				n = 3000;
				hold_request = 0;
			end
			if (n > 0) begin
				results.ready <= 0;
				repeat (n) @(posedge clk);
			end
			results.ready <= 1;
			do @(posedge clk); while (!results.valid);
		end
	end

	// Drive one match; valid stays high into the next item when no gap.
	task automatic send_match(match_t m);
		int n;
		n = send_gaps ? $urandom_range(0, 15) : 0;
		if (n > 0) begin
			pairs.valid <= 0;
			repeat (n) @(posedge clk);
		end
		pairs.valid <= 1;
		pairs.src_x <= m.ax;
		pairs.src_y <= m.ay;
		pairs.dst_x <= m.bx;
		pairs.dst_y <= m.by;
		pairs.set_end <= m.last;
		do @(posedge clk); while (!pairs.ready);
		sb.note_match(m);
	endtask

	// Lower valid, then wait for every result and the block to go quiet.
	task automatic drain();
		pairs.valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 0;
		sb.write_reg(idx, val);
	endtask

	function automatic logic [63:0] pack_row(int c0, int c1, int c2);
		logic [20:0] a, b, c;
		a = c0[20:0];
		b = c1[20:0];
		c = c2[20:0];
		return {1'b0, c, b, a};
	endfunction

	// Load a scale and shift homography and its approximate inverse.
	task automatic load_similarity(int s, int tx, int ty);
		int si;
		si = int'((64'd1 << 32) / s);
		write_reg(REG_FWD0, pack_row(s, 0, tx));
		write_reg(REG_FWD1, pack_row(0, s, ty));
		write_reg(REG_FWD2, pack_row(0, 0, 65536));
		write_reg(REG_INV0, pack_row(si, 0, int'(-(longint'(tx) * si) >>> 16)));
		write_reg(REG_INV1, pack_row(0, si, int'(-(longint'(ty) * si) >>> 16)));
		write_reg(REG_INV2, pack_row(0, 0, 65536));
	endtask

	function automatic logic signed [19:0] clip20(longint v);
		if (v > 524287)
			return 20'sd524287;
		if (v < -524288)
			return -20'sd524288;
		return v[19:0];
	endfunction

	// Mostly matches that follow the current similarity with the given noise,
	// the rest full-range noise.
	function automatic match_t make_match(int s, int tx, int ty, int noise);
		match_t m;
		m.last = ($urandom_range(0, 39) == 0);
		if ($urandom_range(0, 9) < 8) begin
			m.ax = 20'($urandom_range(0, 393216) - 196608);
			m.ay = 20'($urandom_range(0, 393216) - 196608);
			m.bx = clip20(((longint'(m.ax) * s) >>> 16) + tx
				+ longint'($urandom_range(0, 2 * noise)) - noise);
			m.by = clip20(((longint'(m.ay) * s) >>> 16) + ty
				+ longint'($urandom_range(0, 2 * noise)) - noise);
		end else begin
			m.ax = 20'($urandom);
			m.ay = 20'($urandom);
			m.bx = 20'($urandom);
			m.by = 20'($urandom);
		end
		return m;
	endfunction

	task automatic random_run(int count, int s, int tx, int ty, int noise);
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) begin
				send_gaps = $urandom_range(0, 2) != 0;
				recv_gaps = $urandom_range(0, 2) != 0;
			end
			send_match(make_match(s, tx, ty, noise));
		end
	endtask

	localparam int PMAX = 524287;
	localparam int PMIN = -524288;

	initial begin
		match_t m;
		pairs.valid = 0;
		pairs.src_x = 0;
		pairs.src_y = 0;
		pairs.dst_x = 0;
		pairs.dst_y = 0;
		pairs.set_end = 0;
		cfg.valid = 0;
		cfg.index = 0;
		cfg.data = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: identity after reset, field extremes, exact and near hits.
		begin
			int pts[4];
			pts = '{PMIN, PMAX, 0, -1};
			for (int i = 0; i < 4; i++) begin
				m = '{20'(pts[i]), 20'(pts[3 - i]), 20'(pts[i]), 20'(pts[3 - i]), 1'b0};
				send_match(m);
				m = '{20'(pts[i]), 20'(pts[i]), 20'(pts[3 - i]), 20'(pts[3 - i]), i[0]};
				send_match(m);
			end
			m = '{20'sd1000, -20'sd1000, 20'sd1000, -20'sd1000, 1'b0};
			send_match(m);
			m = '{20'sd0, 20'sd0, 20'sd162000, 20'sd0, 1'b0};   // just outside
			send_match(m);
			m = '{20'sd0, 20'sd0, 20'sd150000, 20'sd0, 1'b1};   // just inside
			send_match(m);
		end
		drain();

		// Zero divisor on each side, and writes beyond the register list.
		write_reg(REG_FWD2, 64'd0);
		write_reg(REG_BAD_LO, 64'd0);
		write_reg(REG_BAD_HI, 64'd0);
		for (int i = 0; i < 3; i++)
			send_match('{20'sd100, 20'sd100, 20'sd100, 20'sd100, 1'b0});
		drain();
		write_reg(REG_FWD2, pack_row(0, 0, 65536));
		write_reg(REG_INV2, pack_row(0, 0, 0));
		for (int i = 0; i < 3; i++)
			send_match('{20'sd0, 20'sd0, 20'sd0, 20'sd0, i == 2});
		drain();

		// Similarity with noise; the receiver holds off once mid-run.
		load_similarity(81920, 30000, -20000);
		fork
			random_run(400, 81920, 30000, -20000, 120000);
			begin
				repeat (2000) @(posedge clk);
				hold_request = 1;
			end
		join
		drain();

		// Focal and sigma extremes.
		write_reg(REG_FOCAL, 64'hFF_FFFF_FFFF);
		write_reg(REG_ISQ, 64'hFFFF_FFFF);
		random_run(100, 81920, 30000, -20000, 10);
		drain();
		write_reg(REG_FOCAL, {24'd0, 20'd64, 20'd32});
		write_reg(REG_ISQ, 64'd1 << 20);
		random_run(150, 81920, 30000, -20000, 400000);
		drain();
		write_reg(REG_FOCAL, 64'd0);
		random_run(50, 81920, 30000, -20000, 100000);
		drain();

		// Random and all-ones rows, mostly outliers and odd divisors.
		write_reg(REG_FOCAL, 64'd268435712);
		write_reg(REG_ISQ, 64'd16777216);
		for (int r = 0; r < 3; r++) begin
			write_reg(8'(REG_FWD0 + r), {$urandom, $urandom});
			write_reg(8'(REG_INV0 + r), {$urandom, $urandom});
		end
		random_run(100, 65536, 0, 0, 100000);
		drain();
		for (int r = 0; r < 3; r++) begin
			write_reg(8'(REG_FWD0 + r), 64'h7FFF_FFFF_FFFF_FFFF);
			write_reg(8'(REG_INV0 + r), 64'd0);
		end
		random_run(30, 65536, 0, 0, 100000);
		drain();

		// Mild similarity with a wide noise mix for the bulk of the run.
		load_similarity(62000, -50000, 70000);
		random_run(400, 62000, -50000, 70000, 150000);
		drain();

		// One long set with sigma term zero: every match with nonzero
		// divisors is an inlier scoring the full amount, back to back.
		write_reg(REG_ISQ, 64'd0);
		load_similarity(65536, 0, 0);
		send_gaps = 0;
		recv_gaps = 0;
		for (int i = 0; i < 650; i++) begin
			m = '{20'($urandom_range(0, 131072) - 65536), 20'sd0, 20'sd0,
				20'($urandom_range(0, 131072) - 65536), i == 649};
			send_match(m);
		end
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
